### rtl/lfd_pkg.sv
// Package for the length-prefixed frame deframer: shared types, codes and defaults.
// Used by lfd_cfg_regs, lfd_parser and length_prefixed_frame_deframer_top.
// No dependencies.
package lfd_pkg;

  // Default sizing
  localparam int BoardSlotsDefault  = 16;
  localparam int CounterBitsDefault = 16;

  // Fixed field widths
  localparam int ByteW   = 8;
  localparam int MaskW   = 16;
  localparam int CountW  = 16;
  localparam int KindW   = 2;
  localparam int CfgIdxW = 8;
  localparam int CfgDatW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_START_MARKER  = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_BOARD_UPDATE  = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_KNOWN_MASK    = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_ATTACHED_MASK = 8'd3;

  // Register reset values
  localparam logic [ByteW-1:0] START_MARKER_RST = 8'd237;
  localparam logic [ByteW-1:0] BOARD_UPDATE_RST = 8'd109;

  // Event kinds
  localparam logic [KindW-1:0] KIND_BOARD_DATA = 2'd0;
  localparam logic [KindW-1:0] KIND_OTHER_CMD  = 2'd1;
  localparam logic [KindW-1:0] KIND_STRAY      = 2'd2;
  localparam logic [KindW-1:0] KIND_REJECT     = 2'd3;

  // Configuration register set
  typedef struct packed {
    logic [ByteW-1:0] start_marker;
    logic [ByteW-1:0] board_update_code;
    logic [MaskW-1:0] known_board_mask;
    logic [MaskW-1:0] attached_board_mask;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [KindW-1:0]  event_kind;
    logic [ByteW-1:0]  board_id;
    logic [ByteW-1:0]  byte_offset;
    logic [ByteW-1:0]  data_byte;
    logic              has_data;
    logic              last_of_frame;
    logic [CountW-1:0] stray_byte_count;
    logic [CountW-1:0] bad_frame_count;
  } result_t;

endpackage

### rtl/lfd_cfg_regs.sv
// Configuration register file of the deframer.
// Depends on lfd_pkg (cfg_t, register indexes, reset values).
module lfd_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lfd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [lfd_pkg::CfgDatW-1:0]  cfg_data,
  output lfd_pkg::cfg_t                cfg
);
  import lfd_pkg::*;

  // Writes are always taken; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker        <= START_MARKER_RST;
      cfg.board_update_code   <= BOARD_UPDATE_RST;
      cfg.known_board_mask    <= '0;
      cfg.attached_board_mask <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_MARKER:  cfg.start_marker        <= cfg_data[ByteW-1:0];
        REG_BOARD_UPDATE:  cfg.board_update_code   <= cfg_data[ByteW-1:0];
        REG_KNOWN_MASK:    cfg.known_board_mask    <= cfg_data[MaskW-1:0];
        REG_ATTACHED_MASK: cfg.attached_board_mask <= cfg_data[MaskW-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/lfd_parser.sv
// Byte-wise frame parser: phase state machine, frame context and saturating counters.
// Computes the result for one byte combinationally; state updates on step.
// Depends on lfd_pkg (cfg_t, result_t, event kinds).
module lfd_parser #(
  parameter int BOARD_SLOTS  = lfd_pkg::BoardSlotsDefault,
  parameter int COUNTER_BITS = lfd_pkg::CounterBitsDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lfd_pkg::cfg_t              cfg,
  input  logic                       step,
  input  logic [lfd_pkg::ByteW-1:0]  rx_byte,
  output logic                       emit,
  output lfd_pkg::result_t           result
);
  import lfd_pkg::*;

  localparam int BoardLimit = (BOARD_SLOTS < MaskW) ? BOARD_SLOTS : MaskW;
  localparam logic [ByteW-1:0] BoardLimitB = ByteW'(BoardLimit);

  typedef enum logic [7:0] {
    PH_HUNT   = 8'b0000_0001,
    PH_LEN    = 8'b0000_0010,
    PH_CMD    = 8'b0000_0100,
    PH_BOARD  = 8'b0000_1000,
    PH_DATA   = 8'b0001_0000,
    PH_OTHER  = 8'b0010_0000,
    PH_QUIET  = 8'b0100_0000,
    PH_REJECT = 8'b1000_0000
  } phase_t;

  phase_t                  phase, phase_next;
  logic [ByteW-1:0]        bytes_left, bytes_left_next;
  logic [ByteW-1:0]        frame_board, frame_board_next;
  logic [ByteW-1:0]        deliver_offset, deliver_offset_next;
  logic [COUNTER_BITS-1:0] stray_counter, stray_counter_next;
  logic [COUNTER_BITS-1:0] bad_frame_counter, bad_frame_counter_next;

  logic [ByteW-1:0] left_dec;
  logic             left_zero;
  logic             board_known, board_attached;
  logic [COUNTER_BITS-1:0] stray_inc, bad_inc;
  logic [31:0]      stray_wide, bad_wide;

  // Shared helpers
  assign left_dec  = bytes_left - 1'b1;
  assign left_zero = (left_dec == '0);
  assign board_known    = (rx_byte < BoardLimitB) && cfg.known_board_mask[rx_byte[3:0]];
  assign board_attached = (rx_byte < BoardLimitB) && cfg.attached_board_mask[rx_byte[3:0]];
  assign stray_inc = (stray_counter == '1) ? stray_counter : stray_counter + 1'b1;
  assign bad_inc   = (bad_frame_counter == '1) ? bad_frame_counter : bad_frame_counter + 1'b1;

  // Next state and result for the byte at hand
  always_comb begin
    phase_next             = phase;
    bytes_left_next        = bytes_left;
    frame_board_next       = frame_board;
    deliver_offset_next    = deliver_offset;
    stray_counter_next     = stray_counter;
    bad_frame_counter_next = bad_frame_counter;
    emit                   = 1'b0;
    result.event_kind      = KIND_REJECT;
    result.board_id        = '0;
    result.byte_offset     = '0;
    result.data_byte       = '0;
    result.has_data        = 1'b0;
    result.last_of_frame   = 1'b1;
    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == cfg.start_marker) begin
          phase_next = PH_LEN;
        end else begin
          stray_counter_next   = stray_inc;
          emit                 = 1'b1;
          result.event_kind    = KIND_STRAY;
          result.data_byte     = rx_byte;
          result.has_data      = 1'b1;
          result.last_of_frame = 1'b0;
        end
      end
      PH_LEN: begin
        bytes_left_next     = rx_byte;
        frame_board_next    = '0;
        deliver_offset_next = '0;
        if (rx_byte == '0) begin
          // zero-length frame is rejected here
          bad_frame_counter_next = bad_inc;
          phase_next             = PH_HUNT;
          emit                   = 1'b1;
        end else begin
          phase_next = PH_CMD;
        end
      end
      PH_CMD: begin
        if (rx_byte == cfg.board_update_code) begin
          if (bytes_left < ByteW'(2)) begin
            // board frame too short to name a board
            bad_frame_counter_next = bad_inc;
            phase_next             = PH_HUNT;
            emit                   = 1'b1;
          end else begin
            bytes_left_next = left_dec;
            phase_next      = PH_BOARD;
          end
        end else begin
          bytes_left_next      = left_dec;
          deliver_offset_next  = ByteW'(1);
          phase_next           = left_zero ? PH_HUNT : PH_OTHER;
          emit                 = 1'b1;
          result.event_kind    = KIND_OTHER_CMD;
          result.data_byte     = rx_byte;
          result.has_data      = 1'b1;
          result.last_of_frame = left_zero;
        end
      end
      PH_BOARD: begin
        frame_board_next = rx_byte;
        bytes_left_next  = left_dec;
        if (!board_known) begin
          if (left_zero) begin
            bad_frame_counter_next = bad_inc;
            phase_next             = PH_HUNT;
            emit                   = 1'b1;
            result.board_id        = rx_byte;
          end else begin
            phase_next = PH_REJECT;
          end
        end else if (!board_attached) begin
          phase_next = left_zero ? PH_HUNT : PH_QUIET;
        end else begin
          deliver_offset_next = '0;
          if (left_zero) begin
            // attached board with no data bytes
            phase_next        = PH_HUNT;
            emit              = 1'b1;
            result.event_kind = KIND_BOARD_DATA;
            result.board_id   = rx_byte;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_DATA, PH_OTHER: begin
        bytes_left_next      = left_dec;
        deliver_offset_next  = deliver_offset + 1'b1;
        emit                 = 1'b1;
        result.event_kind    = (phase == PH_DATA) ? KIND_BOARD_DATA : KIND_OTHER_CMD;
        result.board_id      = (phase == PH_DATA) ? frame_board : '0;
        result.byte_offset   = deliver_offset;
        result.data_byte     = rx_byte;
        result.has_data      = 1'b1;
        result.last_of_frame = left_zero;
        if (left_zero) begin
          phase_next = PH_HUNT;
        end
      end
      PH_QUIET: begin
        bytes_left_next = left_dec;
        if (left_zero) begin
          phase_next = PH_HUNT;
        end
      end
      PH_REJECT: begin
        bytes_left_next = left_dec;
        if (left_zero) begin
          bad_frame_counter_next = bad_inc;
          phase_next             = PH_HUNT;
          emit                   = 1'b1;
          result.board_id        = frame_board;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase

    // Counter values after this byte, low bits
    stray_wide              = 32'(stray_counter_next);
    bad_wide                = 32'(bad_frame_counter_next);
    result.stray_byte_count = stray_wide[CountW-1:0];
    result.bad_frame_count  = bad_wide[CountW-1:0];
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HUNT;
      bytes_left        <= '0;
      frame_board       <= '0;
      deliver_offset    <= '0;
      stray_counter     <= '0;
      bad_frame_counter <= '0;
    end else if (step) begin
      phase             <= phase_next;
      bytes_left        <= bytes_left_next;
      frame_board       <= frame_board_next;
      deliver_offset    <= deliver_offset_next;
      stray_counter     <= stray_counter_next;
      bad_frame_counter <= bad_frame_counter_next;
    end
  end

endmodule

### rtl/length_prefixed_frame_deframer_top.sv
// Length-prefixed frame deframer, top level. Depends on lfd_pkg, lfd_cfg_regs, lfd_parser.
// Path: a byte is taken into the input register, the parser computes its result
// combinationally, and the result register holds it. Throughput: one byte per cycle
// while the result side does not stall; a stalled result holds the parser, and the
// input stalls once both registers are full.
// Reset (rst, synchronous): registers to defaults, parser hunting, counters zero,
// both registers empty.
module length_prefixed_frame_deframer_top #(
  parameter int BOARD_SLOTS  = lfd_pkg::BoardSlotsDefault,
  parameter int COUNTER_BITS = lfd_pkg::CounterBitsDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lfd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [lfd_pkg::CfgDatW-1:0] cfg_data,
  // byte input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lfd_pkg::ByteW-1:0]   rx_byte,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lfd_pkg::KindW-1:0]   event_kind,
  output logic [lfd_pkg::ByteW-1:0]   board_id,
  output logic [lfd_pkg::ByteW-1:0]   byte_offset,
  output logic [lfd_pkg::ByteW-1:0]   data_byte,
  output logic                        has_data,
  output logic                        last_of_frame,
  output logic [lfd_pkg::CountW-1:0]  stray_byte_count,
  output logic [lfd_pkg::CountW-1:0]  bad_frame_count
);
  import lfd_pkg::*;

  cfg_t             cfg;
  logic             in_q_valid;
  logic [ByteW-1:0] in_q_byte;
  logic             advance;
  logic             emit;
  result_t          step_result;
  result_t          out_q;

  lfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Held byte moves through the parser when the result register can take it
  assign advance  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;

  lfd_parser #(
    .BOARD_SLOTS  (BOARD_SLOTS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (advance),
    .rx_byte (in_q_byte),
    .emit    (emit),
    .result  (step_result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q_byte <= rx_byte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_q <= step_result;
    end
  end

  assign event_kind       = out_q.event_kind;
  assign board_id         = out_q.board_id;
  assign byte_offset      = out_q.byte_offset;
  assign data_byte        = out_q.data_byte;
  assign has_data         = out_q.has_data;
  assign last_of_frame    = out_q.last_of_frame;
  assign stray_byte_count = out_q.stray_byte_count;
  assign bad_frame_count  = out_q.bad_frame_count;

endmodule

### tb/length_prefixed_frame_deframer_top_tb.sv
// Self-checking testbench for length_prefixed_frame_deframer_top: a directed table, then
// random frame traffic under several register settings.
// Depends on lfd_pkg and the deframer RTL.
module length_prefixed_frame_deframer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfd_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int SettleCycles  = 6;
  localparam int TailCycles    = 12;
  localparam int HoldCycles    = 300;
  localparam int MaxPrinted    = 200;
  localparam int BoardSlots    = BoardSlotsDefault;

  // parser states of the local model
  typedef enum logic [2:0] {
    HUNTING, GET_LEN, GET_CMD, GET_BOARD, BOARD_DATA, CMD_DATA, DROP_QUIET, DROP_BAD
  } parse_state_t;

  // one directed step: a register write or a byte, optionally with a typed-in result
  typedef struct {
    bit                   is_cfg;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDatW-1:0]   val;
    bit                   typed;
    result_t              want;
  } step_t;

  localparam result_t NO_EVENT = '0;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDatW-1:0] cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [ByteW-1:0]   rx_byte   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [KindW-1:0]   event_kind;
  logic [ByteW-1:0]   board_id;
  logic [ByteW-1:0]   byte_offset;
  logic [ByteW-1:0]   data_byte;
  logic               has_data;
  logic               last_of_frame;
  logic [CountW-1:0]  stray_byte_count;
  logic [CountW-1:0]  bad_frame_count;

  length_prefixed_frame_deframer_top dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .event_kind       (event_kind),
    .board_id         (board_id),
    .byte_offset      (byte_offset),
    .data_byte        (data_byte),
    .has_data         (has_data),
    .last_of_frame    (last_of_frame),
    .stray_byte_count (stray_byte_count),
    .bad_frame_count  (bad_frame_count)
  );

  always #5 clk = ~clk;

  // model copy of registers and parser state
  logic [ByteW-1:0]  m_marker   = START_MARKER_RST;
  logic [ByteW-1:0]  m_code     = BOARD_UPDATE_RST;
  logic [MaskW-1:0]  m_known    = '0;
  logic [MaskW-1:0]  m_attached = '0;
  parse_state_t      pstate     = HUNTING;
  logic [ByteW-1:0]  remaining  = '0;
  logic [ByteW-1:0]  cur_board  = '0;
  logic [ByteW-1:0]  cur_offset = '0;
  logic [CountW-1:0] stray_cnt  = '0;
  logic [CountW-1:0] bad_cnt    = '0;

  result_t expected_events [$];
  int      mismatch_count = 0;
  int      results_seen   = 0;
  int      quiet_cycles   = 0;
  bit      no_idle        = 1'b0;
  bit      hold_req       = 1'b0;

  // directed table: extremes, each event kind, each special case
  step_t directed [32] = '{
    '{1'b0, 8'd0, 16'h0000, 1'b1,
      '{KIND_STRAY, 8'd0, 8'd0, 8'h00, 1'b1, 1'b0, 16'd1, 16'd0}},
    '{1'b0, 8'd0, 16'h00FF, 1'b1,
      '{KIND_STRAY, 8'd0, 8'd0, 8'hFF, 1'b1, 1'b0, 16'd2, 16'd0}},
    // zero length
    '{1'b0, 8'd0, 16'h00ED, 1'b0, NO_EVENT},
    '{1'b0, 8'd0, 16'h0000, 1'b1,
      '{KIND_REJECT, 8'd0, 8'd0, 8'h00, 1'b0, 1'b1, 16'd2, 16'd1}},
    // board frame of length one
    '{1'b0, 8'd0, 16'h00ED, 1'b0, NO_EVENT},
    '{1'b0, 8'd0, 16'h0001, 1'b0, NO_EVENT},
    '{1'b0, 8'd0, 16'h006D, 1'b1,
      '{KIND_REJECT, 8'd0, 8'd0, 8'h00, 1'b0, 1'b1, 16'd2, 16'd2}},
    // other command, marker value as payload
    '{1'b0, 8'd0, 16'h00ED, 1'b0, NO_EVENT},
    '{1'b0, 8'd0, 16'h0002, 1'b0, NO_EVENT},
    '{1'b0, 8'd0, 16'h0042, 1'b0, NO_EVENT},
    '{1'b0, 8'd0, 16'h00ED, 1'b0, NO_EVENT},
    // unknown board with trailing bytes
    '{1'b0, 8'd0, 16'h00ED, 1'b0, NO_EVENT},
    '{1'b0, 8'd0, 16'h0003, 1'b0, NO_EVENT},
    '{1'b0, 8'd0, 16'h006D, 1'b0, NO_EVENT},
    '{1'b0, 8'd0, 16'h00C8, 1'b0, NO_EVENT},
    '{1'b0, 8'd0, 16'h00AA, 1'b1,
      '{KIND_REJECT, 8'd200, 8'd0, 8'h00, 1'b0, 1'b1, 16'd2, 16'd3}},
    // boards 0 and 1 known, only board 0 attached; out-of-range index ignored
    '{1'b1, REG_KNOWN_MASK,    16'h0003, 1'b0, NO_EVENT},
    '{1'b1, REG_ATTACHED_MASK, 16'h0001, 1'b0, NO_EVENT},
    '{1'b1, 8'd200,            16'hFFFF, 1'b0, NO_EVENT},
    // attached board, one data byte
    '{1'b0, 8'd0, 16'h00ED, 1'b0, NO_EVENT},
    '{1'b0, 8'd0, 16'h0003, 1'b0, NO_EVENT},
    '{1'b0, 8'd0, 16'h006D, 1'b0, NO_EVENT},
    '{1'b0, 8'd0, 16'h0000, 1'b0, NO_EVENT},
    '{1'b0, 8'd0, 16'h0011, 1'b0, NO_EVENT},
    // known but not attached: silent
    '{1'b0, 8'd0, 16'h00ED, 1'b0, NO_EVENT},
    '{1'b0, 8'd0, 16'h0002, 1'b0, NO_EVENT},
    '{1'b0, 8'd0, 16'h006D, 1'b0, NO_EVENT},
    '{1'b0, 8'd0, 16'h0001, 1'b0, NO_EVENT},
    // attached board, empty delivery
    '{1'b0, 8'd0, 16'h00ED, 1'b0, NO_EVENT},
    '{1'b0, 8'd0, 16'h0002, 1'b0, NO_EVENT},
    '{1'b0, 8'd0, 16'h006D, 1'b0, NO_EVENT},
    '{1'b0, 8'd0, 16'h0000, 1'b1,
      '{KIND_BOARD_DATA, 8'd0, 8'd0, 8'h00, 1'b0, 1'b1, 16'd2, 16'd3}}
  };

  function automatic logic [CountW-1:0] bump(input logic [CountW-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic bit board_in(input logic [MaskW-1:0] mask, input logic [ByteW-1:0] id);
    return (int'(id) < BoardSlots) && (id < 8'd16) && mask[id[3:0]];
  endfunction

  function automatic result_t make_event(input logic [KindW-1:0] kind,
                                         input logic [ByteW-1:0] board,
                                         input logic [ByteW-1:0] off,
                                         input logic [ByteW-1:0] data,
                                         input logic has, input logic last);
    return '{kind, board, off, data, has, last, stray_cnt, bad_cnt};
  endfunction

  function automatic result_t reject_frame(input logic [ByteW-1:0] board);
    bad_cnt = bump(bad_cnt);
    pstate  = HUNTING;
    return make_event(KIND_REJECT, board, 8'd0, 8'd0, 1'b0, 1'b1);
  endfunction

  // advance the model by one byte; returns 1 when the byte yields a result
  function automatic bit deframe_byte(input logic [ByteW-1:0] b, output result_t ev);
    bit got;
    logic last;
    got = 1'b0;
    ev  = NO_EVENT;
    case (pstate)
      HUNTING: begin
        if (b == m_marker) begin
          pstate = GET_LEN;
        end else begin
          stray_cnt = bump(stray_cnt);
          ev  = make_event(KIND_STRAY, 8'd0, 8'd0, b, 1'b1, 1'b0);
          got = 1'b1;
        end
      end
      GET_LEN: begin
        remaining  = b;
        cur_board  = '0;
        cur_offset = '0;
        if (b == 8'd0) begin
          ev  = reject_frame(8'd0);
          got = 1'b1;
        end else begin
          pstate = GET_CMD;
        end
      end
      GET_CMD: begin
        if (b == m_code) begin
          if (remaining < 8'd2) begin
            ev  = reject_frame(8'd0);
            got = 1'b1;
          end else begin
            remaining = remaining - 1'b1;
            pstate    = GET_BOARD;
          end
        end else begin
          remaining  = remaining - 1'b1;
          last       = (remaining == 8'd0);
          ev         = make_event(KIND_OTHER_CMD, 8'd0, 8'd0, b, 1'b1, last);
          got        = 1'b1;
          cur_offset = 8'd1;
          pstate     = last ? HUNTING : CMD_DATA;
        end
      end
      GET_BOARD: begin
        cur_board = b;
        remaining = remaining - 1'b1;
        if (!board_in(m_known, b)) begin
          if (remaining == 8'd0) begin
            ev  = reject_frame(b);
            got = 1'b1;
          end else begin
            pstate = DROP_BAD;
          end
        end else if (!board_in(m_attached, b)) begin
          pstate = (remaining == 8'd0) ? HUNTING : DROP_QUIET;
        end else begin
          cur_offset = '0;
          if (remaining == 8'd0) begin
            pstate = HUNTING;
            ev     = make_event(KIND_BOARD_DATA, b, 8'd0, 8'd0, 1'b0, 1'b1);
            got    = 1'b1;
          end else begin
            pstate = BOARD_DATA;
          end
        end
      end
      BOARD_DATA, CMD_DATA: begin
        remaining = remaining - 1'b1;
        last      = (remaining == 8'd0);
        if (pstate == BOARD_DATA)
          ev = make_event(KIND_BOARD_DATA, cur_board, cur_offset, b, 1'b1, last);
        else
          ev = make_event(KIND_OTHER_CMD, 8'd0, cur_offset, b, 1'b1, last);
        got        = 1'b1;
        cur_offset = cur_offset + 1'b1;
        if (last) pstate = HUNTING;
      end
      DROP_QUIET: begin
        remaining = remaining - 1'b1;
        if (remaining == 8'd0) pstate = HUNTING;
      end
      DROP_BAD: begin
        remaining = remaining - 1'b1;
        if (remaining == 8'd0) begin
          ev  = reject_frame(cur_board);
          got = 1'b1;
        end
      end
      default: pstate = HUNTING;
    endcase
    return got;
  endfunction

  // mostly no gap, sometimes a short one, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report(input string msg);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // offer one byte, wait for it to be taken, then log its expected result
  task automatic send_byte(input logic [ByteW-1:0] b, input bit typed, input result_t want);
    int gap;
    bit got;
    result_t ev;
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = deframe_byte(b, ev);
    if (typed) expected_events.insert(expected_events.size(), want);
    else if (got) expected_events.insert(expected_events.size(), ev);
  endtask

  // register write, only once the block has drained
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_START_MARKER:  m_marker   = val[ByteW-1:0];
      REG_BOARD_UPDATE:  m_code     = val[ByteW-1:0];
      REG_KNOWN_MASK:    m_known    = val[MaskW-1:0];
      REG_ATTACHED_MASK: m_attached = val[MaskW-1:0];
      default: ;
    endcase
  endtask

  // upper bits of the byte-wide registers get junk that must be dropped
  task automatic apply_setting(input logic [ByteW-1:0] marker, input logic [ByteW-1:0] code,
                               input logic [MaskW-1:0] known, input logic [MaskW-1:0] attached);
    write_reg(REG_START_MARKER,  {8'($urandom), marker});
    write_reg(REG_BOARD_UPDATE,  {8'($urandom), code});
    write_reg(REG_KNOWN_MASK,    known);
    write_reg(REG_ATTACHED_MASK, attached);
  endtask

  // random traffic: mostly whole frames, some noise and cut-off frames
  task automatic run_random_phase(input int budget);
    int sent, sel, r, len, n_send;
    logic [ByteW-1:0] frame_q [$];
    sent = 0;
    while (sent < budget) begin
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        repeat ($urandom_range(1, 4)) begin
          send_byte(8'($urandom), 1'b0, NO_EVENT);
          sent++;
        end
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5)       len = 0;
        else if (r < 10) len = 1;
        else if (r < 70) len = $urandom_range(2, 6);
        else if (r < 95) len = $urandom_range(7, 20);
        else             len = $urandom_range(100, 255);
        frame_q = {};
        frame_q.insert(frame_q.size(), m_marker);
        frame_q.insert(frame_q.size(), 8'(len));
        for (int k = 0; k < len; k++) begin
          if (k == 0) begin
            frame_q.insert(frame_q.size(),
                           ($urandom_range(0, 99) < 65) ? m_code : 8'($urandom));
          end else if (k == 1 && frame_q[2] == m_code) begin
            r = $urandom_range(0, 99);
            if (r < 75)      frame_q.insert(frame_q.size(), 8'($urandom_range(0, 15)));
            else if (r < 88) frame_q.insert(frame_q.size(), 8'($urandom_range(16, 31)));
            else             frame_q.insert(frame_q.size(), 8'($urandom));
          end else begin
            frame_q.insert(frame_q.size(), 8'($urandom));
          end
        end
        // a cut-off frame leaves the parser mid-frame for whatever follows
        n_send = (sel < 20) ? $urandom_range(1, frame_q.size() - 1) : frame_q.size();
        for (int k = 0; k < n_send; k++) begin
          send_byte(frame_q[k], 1'b0, NO_EVENT);
          sent++;
        end
      end
    end
  endtask

  // result side: compare against the oldest expectation, then pick the next stall
  always @(posedge clk) begin : result_side
    result_t seen, want;
    int stall_left, hold_left;
    bit hold_done;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = '{event_kind, board_id, byte_offset, data_byte, has_data, last_of_frame,
                 stray_byte_count, bad_frame_count};
        results_seen++;
        if (expected_events.size() == 0) begin
          report($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_events[0];
          expected_events.delete(0);
          if (seen.event_kind !== want.event_kind)
            report($sformatf("result %0d event_kind %0d, expected %0d",
                             results_seen, seen.event_kind, want.event_kind));
          if (seen.board_id !== want.board_id)
            report($sformatf("result %0d board_id %0d, expected %0d",
                             results_seen, seen.board_id, want.board_id));
          if (seen.byte_offset !== want.byte_offset)
            report($sformatf("result %0d byte_offset %0d, expected %0d",
                             results_seen, seen.byte_offset, want.byte_offset));
          if (seen.data_byte !== want.data_byte)
            report($sformatf("result %0d data_byte %0h, expected %0h",
                             results_seen, seen.data_byte, want.data_byte));
          if (seen.has_data !== want.has_data)
            report($sformatf("result %0d has_data %0b, expected %0b",
                             results_seen, seen.has_data, want.has_data));
          if (seen.last_of_frame !== want.last_of_frame)
            report($sformatf("result %0d last_of_frame %0b, expected %0b",
                             results_seen, seen.last_of_frame, want.last_of_frame));
          if (seen.stray_byte_count !== want.stray_byte_count)
            report($sformatf("result %0d stray_byte_count %0d, expected %0d",
                             results_seen, seen.stray_byte_count, want.stray_byte_count));
          if (seen.bad_frame_count !== want.bad_frame_count)
            report($sformatf("result %0d bad_frame_count %0d, expected %0d",
                             results_seen, seen.bad_frame_count, want.bad_frame_count));
        end
      end
      // one long hold-off so the block backs up into its input
      if (hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!no_idle) stall_left = pick_gap();
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) write_reg(directed[i].idx, directed[i].val);
      else send_byte(directed[i].val[ByteW-1:0], directed[i].typed, directed[i].want);
    end

    // random phases under changing settings, extremes first
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_setting(8'h00, 8'hFF, 16'hFFFF, 16'hFFFF);
        1: apply_setting(8'hFF, 8'h00, 16'h0000, 16'h0000);
        default: apply_setting(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      endcase
      if (p == 5) write_reg(8'($urandom_range(4, 255)), 16'($urandom));
      no_idle = (p == 3);
      if (p == 4) hold_req = 1'b1;
      run_random_phase(150);
    end

    // default registers again, all boards attached
    apply_setting(START_MARKER_RST, BOARD_UPDATE_RST, 16'hFFFF, 16'hFFFF);
    no_idle = 1'b0;
    run_random_phase(40);

    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0 && expected_events.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
